/* design/desks_pkg.sv */
`default_nettype none

package desks_pkg;

   localparam int KeyW   = 64;
   localparam int CdW    = 56;
   localparam int HalfW  = 28;
   localparam int SubW   = 48;
   localparam int RoundW = 4;

   localparam logic [RoundW-1:0] LastRound = 4'd15;

   // Bit r is set where round r rotates both halves by two positions.
   localparam logic [15:0] RotTwoMask = 16'b0111_1110_1111_1100;

   localparam logic [6:0] Pc1Tab [CdW] = '{
      7'd57, 7'd49, 7'd41, 7'd33, 7'd25, 7'd17, 7'd9,
      7'd1,  7'd58, 7'd50, 7'd42, 7'd34, 7'd26, 7'd18,
      7'd10, 7'd2,  7'd59, 7'd51, 7'd43, 7'd35, 7'd27,
      7'd19, 7'd11, 7'd3,  7'd60, 7'd52, 7'd44, 7'd36,
      7'd63, 7'd55, 7'd47, 7'd39, 7'd31, 7'd23, 7'd15,
      7'd7,  7'd62, 7'd54, 7'd46, 7'd38, 7'd30, 7'd22,
      7'd14, 7'd6,  7'd61, 7'd53, 7'd45, 7'd37, 7'd29,
      7'd21, 7'd13, 7'd5,  7'd28, 7'd20, 7'd12, 7'd4
   };

   localparam logic [6:0] Pc2Tab [SubW] = '{
      7'd14, 7'd17, 7'd11, 7'd24, 7'd1,  7'd5,
      7'd3,  7'd28, 7'd15, 7'd6,  7'd21, 7'd10,
      7'd23, 7'd19, 7'd12, 7'd4,  7'd26, 7'd8,
      7'd16, 7'd7,  7'd27, 7'd20, 7'd13, 7'd2,
      7'd41, 7'd52, 7'd31, 7'd37, 7'd47, 7'd55,
      7'd30, 7'd40, 7'd51, 7'd45, 7'd33, 7'd48,
      7'd44, 7'd49, 7'd39, 7'd56, 7'd34, 7'd53,
      7'd46, 7'd42, 7'd50, 7'd36, 7'd29, 7'd32
   };

   typedef struct packed {
      logic load;
      logic shift;
      logic two;
   } cell_ctrl_type;

   // DES bit n of the key sits at word bit 64 - n.
   function automatic logic [CdW-1:0] pc1(input logic [KeyW-1:0] key);
      logic [CdW-1:0] sel;
      for (int i = 0; i < CdW; i++) begin
         sel[6'(CdW-1-i)] = key[6'(KeyW - int'(Pc1Tab[i]))];
      end
      return sel;
   endfunction

   // Position n of C||D sits at word bit 56 - n.
   function automatic logic [SubW-1:0] pc2(input logic [CdW-1:0] cd);
      logic [SubW-1:0] sk;
      for (int i = 0; i < SubW; i++) begin
         sk[6'(SubW-1-i)] = cd[6'(CdW - int'(Pc2Tab[i]))];
      end
      return sk;
   endfunction

endpackage

`default_nettype wire

/* design/desks_req_if.sv */
`default_nettype none

interface desks_req_if
   import desks_pkg::*;
();
   logic            valid;
   logic            ready;
   logic [KeyW-1:0] cipher_key;

   modport source (output valid, output cipher_key, input ready);
   modport sink (input valid, input cipher_key, output ready);
endinterface

`default_nettype wire

/* design/desks_rsp_if.sv */
`default_nettype none

interface desks_rsp_if
   import desks_pkg::*;
();
   logic              valid;
   logic              ready;
   logic [RoundW-1:0] round_number;
   logic [SubW-1:0]   subkey;
   logic              last_round;

   modport source (output valid, output round_number, output subkey, output last_round,
                   input ready);
   modport sink (input valid, input round_number, input subkey, input last_round,
                 output ready);
endinterface

`default_nettype wire

/* design/desks_cell.sv */
`default_nettype none

module desks_cell
   import desks_pkg::*;
(
   input  wire logic          clock,
   input  wire cell_ctrl_type ctrl,
   input  wire logic          load_bit,
   input  wire logic          from_one,
   input  wire logic          from_two,
   output logic               bit_q,
   output logic               bit_next
);

   logic bit_ff;

   // The value this bit takes after this round's rotation.
   assign bit_next = ctrl.two ? from_two : from_one;
   assign bit_q    = bit_ff;

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         bit_ff <= load_bit;
      end else if (ctrl.shift) begin
         bit_ff <= bit_next;
      end
   end

endmodule

`default_nettype wire

/* design/des_round_key_schedule_core.sv */
`default_nettype none

// Channel    Direction  Payload
// req_chan   in         cipher_key[63:0]
// rsp_chan   out        round_number[3:0], subkey[47:0], last_round
//
// A key is loaded through PC-1 into a ring of 56 bit cells, two 28-bit halves.
// Every cycle in which the result register is free, each cell takes its
// neighbor's bit one or two places over, and PC-2 of the rotated ring is
// registered as the next round key, sixteen round keys per key.
// A new key is taken in the same cycle as the sixteenth round key, so keys
// follow each other without a gap. A stall on rsp_chan freezes the ring.
// Reset clears the control state only.
module des_round_key_schedule_core
   import desks_pkg::*;
(
   input  wire logic  clock,
   input  wire logic  reset,
   desks_req_if.sink  req_chan,
   desks_rsp_if.source rsp_chan
);

   logic              active_ff, active_in;
   logic [RoundW-1:0] round_ff, round_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [RoundW-1:0] rsp_round_ff;
   logic [SubW-1:0]   rsp_subkey_ff;
   logic              rsp_last_ff;

   logic              advance;
   logic              accept;
   logic              at_last;
   logic [CdW-1:0]    load_cd;
   logic [CdW-1:0]    ring_q;
   logic [CdW-1:0]    ring_next;
   cell_ctrl_type     ctrl;

   assign at_last = (round_ff == LastRound);
   assign advance = active_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !active_ff || (advance && at_last);
   assign accept  = req_chan.valid && req_chan.ready;
   assign load_cd = pc1(req_chan.cipher_key);

   assign ctrl.load  = accept;
   assign ctrl.shift = advance;
   assign ctrl.two   = RotTwoMask[round_ff];

   for (genvar j = 0; j < CdW; j++) begin : g_ring
      localparam int Base = (j / HalfW) * HalfW;
      localparam int Loc  = j % HalfW;
      localparam int Src1 = Base + ((Loc + HalfW - 1) % HalfW);
      localparam int Src2 = Base + ((Loc + HalfW - 2) % HalfW);

      desks_cell u_cell (
         .clock    (clock),
         .ctrl     (ctrl),
         .load_bit (load_cd[j]),
         .from_one (ring_q[Src1]),
         .from_two (ring_q[Src2]),
         .bit_q    (ring_q[j]),
         .bit_next (ring_next[j])
      );
   end

   always_comb begin
      active_in    = active_ff;
      round_in     = round_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (advance) begin
         rsp_valid_in = 1'b1;
         round_in     = round_ff + 1'b1;
         if (at_last) begin
            active_in = 1'b0;
         end
      end
      if (accept) begin
         active_in = 1'b1;
         round_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         round_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         round_ff     <= round_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_round_ff  <= round_ff;
         rsp_subkey_ff <= pc2(ring_next);
         rsp_last_ff   <= at_last;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.round_number = rsp_round_ff;
   assign rsp_chan.subkey       = rsp_subkey_ff;
   assign rsp_chan.last_round   = rsp_last_ff;

endmodule

`default_nettype wire
